@@ rtl/ssid_pkg.sv @@
// ----------------------------------------------------------------------------
// ssid_pkg: shared types and constants of the sorted set intersect unit
// Sizes, payload structs, codes and compare result type.
// ----------------------------------------------------------------------------
`default_nettype none

package ssid_pkg;

	// list storage sizes
	localparam int LIST_DEPTH = 32;
	localparam int KEY_WIDTH  = 32;

	// stored key width: input keys are 32 bits, reduced to KEY_WIDTH
	localparam int STORE_W = (KEY_WIDTH < 32) ? KEY_WIDTH : 32;
	// sign handling is enabled when KEY_WIDTH is 32 or less
	localparam bit SIGN_ON = (KEY_WIDTH <= 32);

	localparam int CNT_W  = $clog2(LIST_DEPTH + 1);
	localparam int ADDR_W = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
	localparam int RES_W  = $clog2(2 * LIST_DEPTH + 1);

	// input item kinds
	typedef enum logic [1:0] {
		KIND_LOAD_A = 2'd0,
		KIND_LOAD_B = 2'd1,
		KIND_RUN    = 2'd2
	} kind_t;

	// configuration register indexes
	localparam logic [1:0] CFG_KEEP_UNMATCHED = 2'd0;
	localparam logic [1:0] CFG_SIGNED_KEYS    = 2'd1;

	typedef struct packed {
		logic [1:0]  kind;
		logic [31:0] key;
	} in_item_t;

	typedef struct packed {
		logic [31:0] out_key;
		logic        is_empty;
		logic [6:0]  result_count;
		logic        overflow;
		logic        last;
	} out_item_t;

	typedef struct packed {
		logic lt;
		logic eq;
	} cmp_res_t;

endpackage

`default_nettype wire

@@ rtl/ssid_cmp.sv @@
// ----------------------------------------------------------------------------
// ssid_cmp: shared key comparator
// Orders two stored keys, unsigned or as two's complement.
// ----------------------------------------------------------------------------
`default_nettype none

module ssid_cmp (
	input  wire logic [ssid_pkg::STORE_W-1:0] a,
	input  wire logic [ssid_pkg::STORE_W-1:0] b,
	input  wire logic                         signed_mode,
	output ssid_pkg::cmp_res_t                res
);

	logic [ssid_pkg::STORE_W-1:0] a_ord;
	logic [ssid_pkg::STORE_W-1:0] b_ord;
	logic                         flip;

	// flip the sign bit so an unsigned compare gives the signed order
	assign flip = signed_mode & ssid_pkg::SIGN_ON;

	always_comb begin
		a_ord = a;
		b_ord = b;
		a_ord[ssid_pkg::STORE_W-1] = a[ssid_pkg::STORE_W-1] ^ flip;
		b_ord[ssid_pkg::STORE_W-1] = b[ssid_pkg::STORE_W-1] ^ flip;
	end

	assign res.lt = (a_ord < b_ord);
	assign res.eq = (a_ord == b_ord);

endmodule

`default_nettype wire

@@ rtl/sorted_set_intersect_or_difference_unit.sv @@
// ----------------------------------------------------------------------------
// sorted_set_intersect_or_difference_unit: sorted list merge engine
// Stores two ascending key lists and merges them on a run item, giving
// either the matched keys or all unmatched keys in ascending order.
// ----------------------------------------------------------------------------
// Usage:
//   in_data carries kind and key. Kind load-first / load-second appends the
//   key to a list; a full list drops the key and sets the sticky overflow
//   flag. Kind run merges the lists; unused kinds are swallowed.
//   A transfer happens on a rising edge with valid high and stall low.
//   While a run is in progress in_stall stays high.
//   A run makes up to two passes over the lists through one registered read
//   port per list and one shared comparator: a counting pass and, if it
//   counted any result, an emitting pass. Each merge step reads the lists
//   (ST_FETCH) and then compares and advances the pointers (ST_STEP).
//   An empty result gives a single item with is_empty and last set.
//   Results leave through an output register; a stalled result holds, and
//   the emitting pass waits until the register frees up.
//   The user must write the configuration port (cfg_we, cfg_index, cfg_data)
//   only while idle; the block does not enforce this. Reset clears the counts,
//   overflow flag and registers; list contents stay undefined until loaded.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_set_intersect_or_difference_unit (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire ssid_pkg::in_item_t  in_data,
	output logic                     out_valid,
	input  wire logic                out_stall,
	output ssid_pkg::out_item_t      out_data,
	input  wire logic                cfg_we,
	input  wire logic [1:0]          cfg_index,
	input  wire logic                cfg_data
);

	localparam int SW = ssid_pkg::STORE_W;
	localparam int CW = ssid_pkg::CNT_W;
	localparam int AW = ssid_pkg::ADDR_W;
	localparam int RW = ssid_pkg::RES_W;

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_FETCH = 4'b0010,
		ST_STEP  = 4'b0100,
		ST_EMPTY = 4'b1000
	} state_t;

	state_t state_q;

	logic [SW-1:0] list_a [ssid_pkg::LIST_DEPTH];
	logic [SW-1:0] list_b [ssid_pkg::LIST_DEPTH];
	logic [SW-1:0] a_rd_q;
	logic [SW-1:0] b_rd_q;

	logic [CW-1:0] fc_q;
	logic [CW-1:0] sc_q;
	logic [CW-1:0] i_q;
	logic [CW-1:0] j_q;
	logic [RW-1:0] cnt_q;
	logic [RW-1:0] emit_q;
	logic          pass_q;
	logic          dropped_q;
	logic          keep_q;
	logic          signed_q;

	logic                out_valid_q;
	ssid_pkg::out_item_t out_q;

	ssid_pkg::cmp_res_t cmp;

	logic          in_xfer;
	logic          out_free;
	logic          out_load;
	logic          a_ok;
	logic          b_ok;
	logic          take_a;
	logic          take_b;
	logic          emit;
	logic          done;
	logic [SW-1:0] emit_key;
	logic          emit_last;

	assign in_stall  = (state_q != ST_IDLE);
	assign in_xfer   = in_valid & ~in_stall;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign out_free  = ~out_valid_q | ~out_stall;

	// output register takes a new result this cycle
	assign out_load = out_free &&
		((state_q == ST_EMPTY) || (state_q == ST_STEP && !done && pass_q && emit));

	// shared comparator
	ssid_cmp u_cmp (
		.a           (a_rd_q),
		.b           (b_rd_q),
		.signed_mode (signed_q),
		.res         (cmp)
	);

	// decide one merge step
	always_comb begin
		a_ok     = (i_q < fc_q);
		b_ok     = (j_q < sc_q);
		take_a   = 1'b0;
		take_b   = 1'b0;
		emit     = 1'b0;
		done     = 1'b0;
		emit_key = a_rd_q;
		if (a_ok && b_ok) begin
			if (cmp.eq) begin
				take_a = 1'b1;
				take_b = 1'b1;
				emit   = ~keep_q;
			end else if (cmp.lt) begin
				take_a = 1'b1;
				emit   = keep_q;
			end else begin
				take_b   = 1'b1;
				emit     = keep_q;
				emit_key = b_rd_q;
			end
		end else if (a_ok && keep_q) begin
			take_a = 1'b1;
			emit   = 1'b1;
		end else if (b_ok && keep_q) begin
			take_b   = 1'b1;
			emit     = 1'b1;
			emit_key = b_rd_q;
		end else begin
			done = 1'b1;
		end
		emit_last = ((emit_q + RW'(1)) == cnt_q);
	end

	// list memories: write on load, registered read at the merge pointers
	always_ff @(posedge clk) begin
		if (in_xfer && in_data.kind == ssid_pkg::KIND_LOAD_A &&
		    fc_q < CW'(ssid_pkg::LIST_DEPTH)) begin
			list_a[fc_q[AW-1:0]] <= in_data.key[SW-1:0];
		end
		if (in_xfer && in_data.kind == ssid_pkg::KIND_LOAD_B &&
		    sc_q < CW'(ssid_pkg::LIST_DEPTH)) begin
			list_b[sc_q[AW-1:0]] <= in_data.key[SW-1:0];
		end
		a_rd_q <= list_a[i_q[AW-1:0]];
		b_rd_q <= list_b[j_q[AW-1:0]];
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			keep_q   <= 1'b0;
			signed_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				ssid_pkg::CFG_KEEP_UNMATCHED: keep_q   <= cfg_data;
				ssid_pkg::CFG_SIGNED_KEYS:    signed_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// sequencer: loads, counting pass, emitting pass, output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			fc_q        <= '0;
			sc_q        <= '0;
			i_q         <= '0;
			j_q         <= '0;
			cnt_q       <= '0;
			emit_q      <= '0;
			pass_q      <= 1'b0;
			dropped_q   <= 1'b0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			// load a new result, or drop the held one once it transfers
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						case (in_data.kind)
							ssid_pkg::KIND_LOAD_A: begin
								if (fc_q < CW'(ssid_pkg::LIST_DEPTH)) fc_q <= fc_q + CW'(1);
								else dropped_q <= 1'b1;
							end
							ssid_pkg::KIND_LOAD_B: begin
								if (sc_q < CW'(ssid_pkg::LIST_DEPTH)) sc_q <= sc_q + CW'(1);
								else dropped_q <= 1'b1;
							end
							ssid_pkg::KIND_RUN: begin
								i_q    <= '0;
								j_q    <= '0;
								cnt_q  <= '0;
								pass_q <= 1'b0;
								if (fc_q != '0 && sc_q != '0) state_q <= ST_FETCH;
								else state_q <= ST_EMPTY;
							end
							default: ;
						endcase
					end
				end
				ST_FETCH: begin
					state_q <= ST_STEP;
				end
				ST_STEP: begin
					if (done) begin
						if (pass_q) begin
							state_q <= ST_IDLE;
						end else if (cnt_q == '0) begin
							state_q <= ST_EMPTY;
						end else begin
							pass_q  <= 1'b1;
							i_q     <= '0;
							j_q     <= '0;
							emit_q  <= '0;
							state_q <= ST_FETCH;
						end
					end else if (pass_q && emit) begin
						// hold until the output register can take the key
						if (out_free) begin
							out_q.out_key         <= 32'(emit_key);
							out_q.is_empty        <= 1'b0;
							out_q.result_count    <= 7'(cnt_q);
							out_q.overflow        <= dropped_q;
							out_q.last            <= emit_last;
							emit_q                <= emit_q + RW'(1);
							if (take_a) i_q <= i_q + CW'(1);
							if (take_b) j_q <= j_q + CW'(1);
							state_q <= emit_last ? ST_IDLE : ST_FETCH;
						end
					end else begin
						if (emit) cnt_q <= cnt_q + RW'(1);
						if (take_a) i_q <= i_q + CW'(1);
						if (take_b) j_q <= j_q + CW'(1);
						state_q <= ST_FETCH;
					end
				end
				ST_EMPTY: begin
					if (out_free) begin
						out_q.out_key      <= '0;
						out_q.is_empty     <= 1'b1;
						out_q.result_count <= '0;
						out_q.overflow     <= dropped_q;
						out_q.last         <= 1'b1;
						state_q            <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

@@ rtl/ssid_checker.sv @@
// ----------------------------------------------------------------------------
// ssid_checker: port-level checks of the sorted set intersect unit
// Watches the channels and flags inconsistent result items.
// ----------------------------------------------------------------------------
`default_nettype none

module ssid_checker (
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                in_stall,
	input wire logic                out_valid,
	input wire logic                out_stall,
	input wire ssid_pkg::out_item_t out_data
);

	// hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("stalled result changed");

	// an empty result is a lone final item with zero count
	a_empty_form: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.is_empty |->
			out_data.last && out_data.result_count == 7'd0)
		else $error("empty result malformed");

	// a real key comes with a nonzero count
	a_count_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.is_empty |-> out_data.result_count != 7'd0)
		else $error("result key with zero count");

	// input stays stalled while the run has more results to give
	a_busy_mid_run: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.last |-> in_stall)
		else $error("input accepted in the middle of a run");

endmodule

bind sorted_set_intersect_or_difference_unit ssid_checker u_ssid_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_data  (out_data)
);

`default_nettype wire
